// ----- rtl/core/bqum_pkg.sv -----
// Shared types, constants and coefficient helper for the biquad upmixer.
// No dependencies; the sequencer, datapath, top level and testbench import this package.
package bqum_pkg;

  localparam int SAMPLE_WIDTH_DEF   = 24;
  localparam int COEF_FRAC_BITS_DEF = 22;

  // Shared multiplier operand and product widths; output history is MUL_W wide.
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;

  // Gain registers are signed Q1.15.
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 15;

  localparam int NUM_FILT          = 6;
  localparam int NUM_CHAN          = 6;
  localparam int NUM_SETS          = 3;
  localparam int NUM_TAPS          = 5;
  localparam int FIRST_GROUP_CHANS = 3;

  // Biquad taps in the order the sequencer multiplies them.
  localparam logic [2:0] TAP_X0 = 3'd0;
  localparam logic [2:0] TAP_X1 = 3'd1;
  localparam logic [2:0] TAP_X2 = 3'd2;
  localparam logic [2:0] TAP_Y1 = 3'd3;
  localparam logic [2:0] TAP_Y2 = 3'd4;

  // Coefficients in units of 1e-4: b0, b1, b2, a1, a2 of low, high and band pass.
  localparam int COEF_DEC [NUM_SETS][NUM_TAPS] = '{
    '{ 6632,  13264,  6632,  12095, 4432 },
    '{ 9223, -18447,  9223, -18391, 8511 },
    '{ 4139,      0, -4139,  -6384, 1722 }
  };

  // Coefficient set used by each filter.
  localparam logic [1:0] FILT_SET [NUM_FILT] = '{2'd0, 2'd1, 2'd2, 2'd2, 2'd1, 2'd0};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAIN1,
    ST_GAIN2,
    ST_MAC,
    ST_FIN,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic       load_x;
    logic       mul_en;
    logic       mul_gain;
    logic       gain_sel;
    logic       cap_g1;
    logic       cap_g2;
    logic       acc_clr;
    logic       acc_add;
    logic       fin;
    logic       out_load;
    logic [2:0] filt;
    logic [2:0] step;
    logic [2:0] chan;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  // Scales a coefficient by 2^frac, rounding to nearest with ties away from zero.
  function automatic longint coef_calc(int n, int frac);
    longint mag;
    longint q;
    mag = longint'((n < 0) ? -n : n) * (longint'(1) << frac);
    q   = (mag + 64'sd5000) / 64'sd10000;
    return (n < 0) ? -q : q;
  endfunction

endpackage

// ----- rtl/core/bqum_in_if.sv -----
// Input channel of the biquad upmixer: valid/ready handshake and one mono sample.
// No dependencies.
interface bqum_in_if #(parameter int SAMPLE_WIDTH = 24);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

// ----- rtl/core/bqum_out_if.sv -----
// Result channel of the biquad upmixer: valid/ready handshake and six channel samples.
// No dependencies.
interface bqum_out_if #(parameter int SAMPLE_WIDTH = 24);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] left_out;
  logic signed [SAMPLE_WIDTH-1:0] center_out;
  logic signed [SAMPLE_WIDTH-1:0] left_side_out;
  logic signed [SAMPLE_WIDTH-1:0] right_side_out;
  logic signed [SAMPLE_WIDTH-1:0] right_out;
  logic signed [SAMPLE_WIDTH-1:0] lfe_out;

  modport source (output valid, output left_out, output center_out, output left_side_out,
                  output right_side_out, output right_out, output lfe_out, input ready);
  modport sink (input valid, input left_out, input center_out, input left_side_out,
                input right_side_out, input right_out, input lfe_out, output ready);
endinterface

// ----- rtl/core/bqum_ctrl.sv -----
// Sequencer of the biquad upmixer: steps the shared multiplier through gains and taps.
// Depends on bqum_pkg.
module bqum_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              enable,
  input  logic              mode,
  input  bqum_pkg::status_t status,
  output bqum_pkg::cmd_t    cmd
);
  import bqum_pkg::*;

  localparam logic [2:0] LAST_FILT_M0 = 3'(NUM_FILT - 2);
  localparam logic [2:0] LAST_FILT_M1 = 3'(NUM_FILT - 1);

  ctrl_state_t state_r, state_nxt;
  logic [2:0]  filt_r, filt_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [2:0]  last_filt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      filt_r  <= '0;
      step_r  <= TAP_X0;
    end else begin
      state_r <= state_nxt;
      filt_r  <= filt_nxt;
      step_r  <= step_nxt;
    end
  end

  assign last_filt = mode ? LAST_FILT_M1 : LAST_FILT_M0;

  always_comb begin
    state_nxt = state_r;
    filt_nxt  = filt_r;
    step_nxt  = step_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.filt  = filt_r;
    cmd.step  = step_r;
    // In mode zero the left channel is unfiltered, so filter f feeds channel f+1.
    cmd.chan  = mode ? filt_r : filt_r + 3'd1;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_x = 1'b1;
          filt_nxt   = '0;
          step_nxt   = TAP_X0;
          state_nxt  = enable ? ST_GAIN1 : ST_OUT;
        end
      end
      ST_GAIN1: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_gain = 1'b1;
        state_nxt    = ST_GAIN2;
      end
      ST_GAIN2: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_gain = 1'b1;
        cmd.gain_sel = 1'b1;
        cmd.cap_g1   = 1'b1;
        state_nxt    = ST_MAC;
      end
      ST_MAC: begin
        cmd.mul_en  = 1'b1;
        cmd.acc_clr = (step_r == TAP_X0);
        cmd.acc_add = (step_r != TAP_X0);
        // The second gain product is still in the product register here.
        cmd.cap_g2  = (filt_r == '0) && (step_r == TAP_X0);
        if (step_r == TAP_Y2) begin
          state_nxt = ST_FIN;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      ST_FIN: begin
        cmd.fin  = 1'b1;
        step_nxt = TAP_X0;
        if (filt_r == last_filt) begin
          state_nxt = ST_OUT;
        end else begin
          filt_nxt  = filt_r + 3'd1;
          state_nxt = ST_MAC;
        end
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/bqum_dp.sv -----
// Datapath of the biquad upmixer: shared multiplier, accumulator, filter history
// and the output register. Depends on bqum_pkg.
module bqum_dp #(
  parameter int SAMPLE_WIDTH   = bqum_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = bqum_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  bqum_pkg::cmd_t                       cmd,
  input  logic                                 enable,
  input  logic                                 mode,
  input  logic signed [bqum_pkg::GAIN_W-1:0]   gain1,
  input  logic signed [bqum_pkg::GAIN_W-1:0]   gain2,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_sample,
  input  logic                                 out_ready,
  output bqum_pkg::status_t                    status,
  output logic                                 out_valid,
  output logic signed [SAMPLE_WIDTH-1:0]       left_out,
  output logic signed [SAMPLE_WIDTH-1:0]       center_out,
  output logic signed [SAMPLE_WIDTH-1:0]       left_side_out,
  output logic signed [SAMPLE_WIDTH-1:0]       right_side_out,
  output logic signed [SAMPLE_WIDTH-1:0]       right_out,
  output logic signed [SAMPLE_WIDTH-1:0]       lfe_out
);
  import bqum_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int ACC_W = PROD_W + 3;

  localparam logic signed [ACC_W-1:0]  RND   = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0]  Y_MAX = (ACC_W'(1) << (MUL_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0]  Y_MIN = ~Y_MAX;
  localparam logic signed [ACC_W-1:0]  S_MAX = (ACC_W'(1) << (SW - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0]  S_MIN = ~S_MAX;
  localparam logic signed [PROD_W-1:0] G_RND = PROD_W'(1) << (GAIN_FRAC - 1);
  localparam logic signed [PROD_W-1:0] G_MAX = (PROD_W'(1) << (SW - 1)) - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] G_MIN = ~G_MAX;

  logic signed [MUL_W-1:0]  coef_w [NUM_SETS][NUM_TAPS];

  logic signed [SW-1:0]     x_r;
  logic signed [SW-1:0]     g1_r;
  logic signed [SW-1:0]     g2_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_neg_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [SW-1:0]     x1_r [NUM_FILT];
  logic signed [SW-1:0]     x2_r [NUM_FILT];
  logic signed [MUL_W-1:0]  y1_r [NUM_FILT];
  logic signed [MUL_W-1:0]  y2_r [NUM_FILT];
  logic signed [SW-1:0]     ch_r [NUM_CHAN];
  logic                     out_valid_r;
  logic signed [SW-1:0]     left_r;
  logic signed [SW-1:0]     center_r;
  logic signed [SW-1:0]     left_side_r;
  logic signed [SW-1:0]     right_side_r;
  logic signed [SW-1:0]     right_r;
  logic signed [SW-1:0]     lfe_r;

  logic [1:0]               set_w;
  logic signed [SW-1:0]     gx_w;
  logic signed [MUL_W-1:0]  opa_w;
  logic signed [MUL_W-1:0]  opb_w;
  logic signed [PROD_W-1:0] prod_w;
  logic signed [PROD_W-1:0] g_round_w;
  logic signed [PROD_W-1:0] g_sh_w;
  logic signed [SW-1:0]     g_sat_w;
  logic signed [ACC_W-1:0]  prod_ext_w;
  logic signed [ACC_W-1:0]  addend_w;
  logic signed [ACC_W-1:0]  sum_w;
  logic signed [ACC_W-1:0]  sh_w;
  logic signed [MUL_W-1:0]  y_sat_w;
  logic signed [SW-1:0]     s_sat_w;

  // Coefficient table, fixed at elaboration.
  for (genvar i = 0; i < NUM_SETS; i++) begin : g_set
    for (genvar j = 0; j < NUM_TAPS; j++) begin : g_tap
      assign coef_w[i][j] = MUL_W'(coef_calc(COEF_DEC[i][j], COEF_FRAC_BITS));
    end
  end

  assign set_w = FILT_SET[cmd.filt];
  assign gx_w  = (cmd.chan < 3'(FIRST_GROUP_CHANS)) ? g1_r : g2_r;

  always_comb begin
    if (cmd.mul_gain) begin
      opa_w = cmd.gain_sel ? MUL_W'(gain2) : MUL_W'(gain1);
      opb_w = MUL_W'(x_r);
    end else begin
      opa_w = coef_w[set_w][cmd.step];
      case (cmd.step)
        TAP_X0:  opb_w = MUL_W'(gx_w);
        TAP_X1:  opb_w = MUL_W'(x1_r[cmd.filt]);
        TAP_X2:  opb_w = MUL_W'(x2_r[cmd.filt]);
        TAP_Y1:  opb_w = y1_r[cmd.filt];
        default: opb_w = y2_r[cmd.filt];
      endcase
    end
  end

  assign prod_w = opa_w * opb_w;

  // Gained sample: round at bit 14, floor shift by 15, saturate.
  assign g_round_w = prod_r + G_RND;
  assign g_sh_w    = g_round_w >>> GAIN_FRAC;
  assign g_sat_w   = (g_sh_w > G_MAX) ? G_MAX[SW-1:0] :
                     (g_sh_w < G_MIN) ? G_MIN[SW-1:0] : g_sh_w[SW-1:0];

  // Feedback taps are subtracted; the rounding half is preloaded into the accumulator.
  assign prod_ext_w = ACC_W'(prod_r);
  assign addend_w   = prod_neg_r ? -prod_ext_w : prod_ext_w;
  assign sum_w      = acc_r + addend_w;
  assign sh_w       = sum_w >>> COEF_FRAC_BITS;
  assign y_sat_w    = (sh_w > Y_MAX) ? Y_MAX[MUL_W-1:0] :
                      (sh_w < Y_MIN) ? Y_MIN[MUL_W-1:0] : sh_w[MUL_W-1:0];
  assign s_sat_w    = (sh_w > S_MAX) ? S_MAX[SW-1:0] :
                      (sh_w < S_MIN) ? S_MIN[SW-1:0] : sh_w[SW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_x) begin
      x_r <= in_sample;
    end
    if (cmd.mul_en) begin
      prod_r     <= prod_w;
      prod_neg_r <= !cmd.mul_gain && ((cmd.step == TAP_Y1) || (cmd.step == TAP_Y2));
    end
    if (cmd.cap_g1) begin
      g1_r <= g_sat_w;
    end
    if (cmd.cap_g2) begin
      g2_r <= g_sat_w;
    end
    if (cmd.acc_clr) begin
      acc_r <= RND;
    end else if (cmd.acc_add) begin
      acc_r <= sum_w;
    end
    if (cmd.fin) begin
      ch_r[cmd.chan] <= s_sat_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_FILT; i++) begin
        x1_r[i] <= '0;
        x2_r[i] <= '0;
        y1_r[i] <= '0;
        y2_r[i] <= '0;
      end
    end else if (cmd.fin) begin
      x2_r[cmd.filt] <= x1_r[cmd.filt];
      x1_r[cmd.filt] <= gx_w;
      y2_r[cmd.filt] <= y1_r[cmd.filt];
      y1_r[cmd.filt] <= y_sat_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (!enable) begin
        left_r       <= x_r;
        center_r     <= '0;
        left_side_r  <= '0;
        right_side_r <= '0;
        right_r      <= '0;
        lfe_r        <= '0;
      end else begin
        left_r       <= mode ? ch_r[0] : g1_r;
        center_r     <= ch_r[1];
        left_side_r  <= ch_r[2];
        right_side_r <= ch_r[3];
        right_r      <= ch_r[4];
        lfe_r        <= ch_r[5];
      end
    end
  end

  assign status.out_free = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign left_out        = left_r;
  assign center_out      = center_r;
  assign left_side_out   = left_side_r;
  assign right_side_out  = right_side_r;
  assign right_out       = right_r;
  assign lfe_out         = lfe_r;

endmodule

// ----- rtl/core/mono_to_six_channel_biquad_upmix_top.sv -----
// Mono to six channel biquad upmixer, top level: register port, sequencer, datapath.
// A new sample is taken only with the sequencer idle, after the last one is finished.
// Mode one runs six filters and mode zero five on the single shared 32x32 multiplier,
// doing two gain products and five taps per filter; a disabled block skips them all.
// Reset (synchronous, active low) clears the filter history and the handshake state and
// loads the registers with enable on, mode zero and both gains at 23198.
// Depends on bqum_pkg, bqum_in_if, bqum_out_if, bqum_ctrl and bqum_dp.
module mono_to_six_channel_biquad_upmix_top #(
  parameter int SAMPLE_WIDTH   = bqum_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = bqum_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  bqum_in_if.sink           in_ch,
  bqum_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import bqum_pkg::*;

  // Register indexes; each register sits at byte address 4 * index.
  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_MODE   = 2'd1;
  localparam logic [1:0] REG_GAIN1  = 2'd2;
  localparam logic [1:0] REG_GAIN2  = 2'd3;

  localparam logic signed [GAIN_W-1:0] GAIN_RST = 16'sd23198;

  logic                     enable_r;
  logic                     mode_r;
  logic signed [GAIN_W-1:0] gain1_r;
  logic signed [GAIN_W-1:0] gain2_r;
  logic                     wr_en;
  logic [1:0]               reg_idx;
  cmd_t                     cmd;
  status_t                  status;

  // The register port never stalls; a write lands at the access phase.
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
      mode_r   <= 1'b0;
      gain1_r  <= GAIN_RST;
      gain2_r  <= GAIN_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ENABLE: enable_r <= pwdata[0];
        REG_MODE:   mode_r   <= pwdata[0];
        REG_GAIN1:  gain1_r  <= pwdata[GAIN_W-1:0];
        REG_GAIN2:  gain2_r  <= pwdata[GAIN_W-1:0];
        default:    enable_r <= enable_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ENABLE: prdata = {31'd0, enable_r};
      REG_MODE:   prdata = {31'd0, mode_r};
      REG_GAIN1:  prdata = {16'd0, gain1_r};
      REG_GAIN2:  prdata = {16'd0, gain2_r};
      default:    prdata = '0;
    endcase
  end

  // The sequencer takes a new item only when idle; a finished result sits in the
  // datapath's output register, so the next item can start while it waits to be taken.
  bqum_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .enable   (enable_r),
    .mode     (mode_r),
    .status   (status),
    .cmd      (cmd)
  );

  // Each filter runs as five multiply steps on the shared multiplier, each product
  // registered before it is accumulated, followed by a finish step that rounds,
  // saturates and updates that filter's history.
  bqum_dp #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .enable         (enable_r),
    .mode           (mode_r),
    .gain1          (gain1_r),
    .gain2          (gain2_r),
    .in_sample      (in_ch.sample_in),
    .out_ready      (out_ch.ready),
    .status         (status),
    .out_valid      (out_ch.valid),
    .left_out       (out_ch.left_out),
    .center_out     (out_ch.center_out),
    .left_side_out  (out_ch.left_side_out),
    .right_side_out (out_ch.right_side_out),
    .right_out      (out_ch.right_out),
    .lfe_out        (out_ch.lfe_out)
  );

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for the mono to six channel biquad upmixer: directed rows, then random phases.
// Depends on bqum_pkg, bqum_in_if, bqum_out_if and the upmixer top level.
module tb_top;
  import bqum_pkg::*;

  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam int FRAC = COEF_FRAC_BITS_DEF;

  // Register map: one 32-bit word per register.
  localparam logic [3:0] ADDR_ENABLE = 4'd0;
  localparam logic [3:0] ADDR_MODE   = 4'd4;
  localparam logic [3:0] ADDR_GAIN1  = 4'd8;
  localparam logic [3:0] ADDR_GAIN2  = 4'd12;

  localparam logic MODE_LEFT_DRY = 1'b0;
  localparam logic MODE_ALL_FILT = 1'b1;

  localparam logic signed [SW-1:0] S_MAX = 24'sh7FFFFF;
  localparam logic signed [SW-1:0] S_MIN = 24'sh800000;
  localparam logic signed [15:0] G_RST = 16'sd23198;
  localparam logic signed [15:0] G_MAX = 16'sh7FFF;
  localparam logic signed [15:0] G_MIN = 16'sh8000;

  localparam int RANDOM_ITEMS = 1700;
  localparam int CYCLE_LIMIT  = 2_000_000;
  // Margin after the last result so that stray results are caught.
  localparam int TAIL_CYCLES  = 60;

  typedef struct packed {
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] center;
    logic signed [SW-1:0] left_side;
    logic signed [SW-1:0] right_side;
    logic signed [SW-1:0] right;
    logic signed [SW-1:0] lfe;
  } upmix_frame_t;

  localparam upmix_frame_t ZERO_FRAME = '0;

  // One directed row: the register setting it runs under, the sample, and an optional
  // hand-written result where the answer is obvious.
  typedef struct {
    logic                 en;
    logic                 md;
    logic signed [15:0]   g1;
    logic signed [15:0]   g2;
    logic signed [SW-1:0] sample;
    bit                   typed;
    upmix_frame_t         want;
  } dir_row_t;

  localparam int N_DIRECTED = 21;

  dir_row_t directed_rows [N_DIRECTED] = '{
    // Fresh filters and a zero sample give silence on every channel.
    '{1'b1, MODE_LEFT_DRY, G_RST, G_RST, 24'sd0, 1'b1, ZERO_FRAME},
    '{1'b1, MODE_LEFT_DRY, G_RST, G_RST, S_MAX, 1'b0, ZERO_FRAME},
    '{1'b1, MODE_LEFT_DRY, G_RST, G_RST, S_MIN, 1'b0, ZERO_FRAME},
    '{1'b1, MODE_LEFT_DRY, G_RST, G_RST, 24'sd1, 1'b0, ZERO_FRAME},
    '{1'b1, MODE_LEFT_DRY, G_RST, G_RST, -24'sd1, 1'b0, ZERO_FRAME},
    '{1'b1, MODE_ALL_FILT, G_RST, G_RST, S_MAX, 1'b0, ZERO_FRAME},
    '{1'b1, MODE_ALL_FILT, G_RST, G_RST, S_MIN, 1'b0, ZERO_FRAME},
    '{1'b1, MODE_ALL_FILT, G_RST, G_RST, 24'sd0, 1'b0, ZERO_FRAME},
    // Gain of minus one on the most negative sample must saturate to the maximum.
    '{1'b1, MODE_LEFT_DRY, G_MIN, G_MIN, S_MIN, 1'b0, ZERO_FRAME},
    '{1'b1, MODE_LEFT_DRY, G_MIN, G_MAX, S_MAX, 1'b0, ZERO_FRAME},
    '{1'b1, MODE_ALL_FILT, G_MAX, G_MIN, S_MIN, 1'b0, ZERO_FRAME},
    '{1'b1, MODE_ALL_FILT, G_MIN, G_MIN, S_MIN, 1'b0, ZERO_FRAME},
    '{1'b1, MODE_ALL_FILT, 16'sd0, 16'sd0, S_MAX, 1'b0, ZERO_FRAME},
    '{1'b1, MODE_LEFT_DRY, G_MAX, G_MAX, 24'sh555555, 1'b0, ZERO_FRAME},
    '{1'b1, MODE_LEFT_DRY, G_MAX, G_MAX, 24'shAAAAAA, 1'b0, ZERO_FRAME},
    // Bypass: left carries the raw sample, everything else is zero.
    '{1'b0, MODE_LEFT_DRY, G_MAX, G_MAX, S_MAX, 1'b1, '{S_MAX, '0, '0, '0, '0, '0}},
    '{1'b0, MODE_ALL_FILT, G_MAX, G_MAX, S_MIN, 1'b1, '{S_MIN, '0, '0, '0, '0, '0}},
    '{1'b0, MODE_ALL_FILT, G_MAX, G_MAX, 24'sd0, 1'b1, ZERO_FRAME},
    '{1'b0, MODE_LEFT_DRY, G_MAX, G_MAX, 24'sh123456, 1'b1,
      '{24'sh123456, '0, '0, '0, '0, '0}},
    // Back to filtering: the history from before the bypass must still be there.
    '{1'b1, MODE_ALL_FILT, G_RST, G_RST, 24'sd0, 1'b0, ZERO_FRAME},
    '{1'b1, MODE_LEFT_DRY, G_RST, G_RST, -24'sd1234567, 1'b0, ZERO_FRAME}
  };

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata;
  wire [31:0] prdata;
  wire pready;

  bqum_in_if #(.SAMPLE_WIDTH(SW)) in_ch ();
  bqum_out_if #(.SAMPLE_WIDTH(SW)) out_ch ();

  mono_to_six_channel_biquad_upmix_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state: our own copy of the registers and of every biquad's history.
  logic               cur_enable;
  logic               cur_mode;
  logic signed [15:0] cur_gain_first;
  logic signed [15:0] cur_gain_second;
  longint             biquad_coef [3][5];
  longint             x_hist [12];
  longint             y_hist [12];

  // Coefficient sets in units of 1e-4, order b0 b1 b2 a1 a2: low, high, band pass.
  int coef_e4 [3][5] = '{
    '{ 6632,  13264,  6632,  12095, 4432 },
    '{ 9223, -18447,  9223, -18391, 8511 },
    '{ 4139,      0, -4139,  -6384, 1722 }
  };
  int filter_kind [6] = '{0, 1, 2, 2, 1, 0};

  upmix_frame_t expected_frames [$];
  int mismatches = 0;
  int results_seen = 0;
  int cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint clamp_to(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  // One Direct Form I step. The full sum is exact in 64 bits, so a single rounding
  // shift gives the same answer as any split accumulation.
  function automatic longint run_biquad(int f, longint x);
    longint acc;
    longint y;
    int k;
    k = filter_kind[f];
    acc = biquad_coef[k][0] * x + biquad_coef[k][1] * x_hist[2*f]
        + biquad_coef[k][2] * x_hist[2*f+1] - biquad_coef[k][3] * y_hist[2*f]
        - biquad_coef[k][4] * y_hist[2*f+1];
    y = clamp_to((acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC, 32);
    x_hist[2*f+1] = x_hist[2*f];
    x_hist[2*f]   = x;
    y_hist[2*f+1] = y_hist[2*f];
    y_hist[2*f]   = y;
    return clamp_to(y, SW);
  endfunction

  function automatic upmix_frame_t predict_upmix(logic signed [SW-1:0] s);
    upmix_frame_t fr;
    longint g1;
    longint g2;
    fr = '0;
    if (!cur_enable) begin
      fr.left = s;
      return fr;
    end
    g1 = clamp_to((longint'(s) * longint'(cur_gain_first) + 16384) >>> 15, SW);
    g2 = clamp_to((longint'(s) * longint'(cur_gain_second) + 16384) >>> 15, SW);
    if (cur_mode == MODE_LEFT_DRY) begin
      // Left is the dry gained sample; filter five keeps its history untouched.
      fr.left       = g1[SW-1:0];
      fr.center     = SW'(run_biquad(0, g1));
      fr.left_side  = SW'(run_biquad(1, g1));
      fr.right_side = SW'(run_biquad(2, g2));
      fr.right      = SW'(run_biquad(3, g2));
      fr.lfe        = SW'(run_biquad(4, g2));
    end else begin
      fr.left       = SW'(run_biquad(0, g1));
      fr.center     = SW'(run_biquad(1, g1));
      fr.left_side  = SW'(run_biquad(2, g1));
      fr.right_side = SW'(run_biquad(3, g2));
      fr.right      = SW'(run_biquad(4, g2));
      fr.lfe        = SW'(run_biquad(5, g2));
    end
    return fr;
  endfunction

  task automatic check_field(string name, logic signed [SW-1:0] want,
                             logic signed [SW-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Result monitor. Values are read in the active region of the rising edge, so they
  // are the ones that the block's flops present before this edge takes effect.
  always @(posedge clk) begin
    upmix_frame_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_frames.size() == 0) begin
        $error("result with no item outstanding: left %0d", out_ch.left_out);
        mismatches++;
      end else begin
        want = expected_frames.pop_front();
        check_field("left_out", want.left, out_ch.left_out);
        check_field("center_out", want.center, out_ch.center_out);
        check_field("left_side_out", want.left_side, out_ch.left_side_out);
        check_field("right_side_out", want.right_side, out_ch.right_side_out);
        check_field("right_out", want.right, out_ch.right_out);
        check_field("lfe_out", want.lfe, out_ch.lfe_out);
      end
    end
  end

  // Watchdog: the slowest legal run is far below this, so hitting it means a hang.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side backpressure. The idle rate is redrawn at regular intervals so that
  // some stretches have ready stuck high and others stall often. Once, after a few
  // hundred results, ready is held low long enough for the block to back up and
  // refuse input while the sender keeps offering items.
  initial begin
    int hold_left;
    int gap_left;
    int idle_pct;
    bit hold_done;
    hold_left = 0;
    gap_left = 0;
    idle_pct = 5;
    hold_done = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (cycle_count % 400 == 0) begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 5;
          default: idle_pct = 30;
        endcase
      end
      if (!hold_done && results_seen >= 300) begin
        hold_left = 600;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (gap_left > 0) begin
        out_ch.ready <= 1'b0;
        gap_left--;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        // Mostly short stalls, with the odd long one.
        gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 90) : $urandom_range(0, 3);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic wait_drained();
    while (expected_frames.size() != 0) @(posedge clk);
  endtask

  // APB write: setup phase, then access phase; the register takes the data at the
  // rising edge where psel, penable, pwrite and pready are all high.
  task automatic reg_write(logic [3:0] addr, logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Registers only change with the block idle, i.e. once every result is back.
  task automatic apply_setting(logic en, logic md, logic signed [15:0] g1,
                               logic signed [15:0] g2);
    wait_drained();
    if (en !== cur_enable) begin
      reg_write(ADDR_ENABLE, {31'd0, en});
      cur_enable = en;
    end
    if (md !== cur_mode) begin
      reg_write(ADDR_MODE, {31'd0, md});
      cur_mode = md;
    end
    if (g1 !== cur_gain_first) begin
      reg_write(ADDR_GAIN1, {{16{g1[15]}}, g1});
      cur_gain_first = g1;
    end
    if (g2 !== cur_gain_second) begin
      reg_write(ADDR_GAIN2, {{16{g2[15]}}, g2});
      cur_gain_second = g2;
    end
  endtask

  // Offers one sample and, once it is taken, queues what must come out for it. A
  // hand-written frame replaces the prediction, but the history still advances.
  task automatic offer_sample(logic signed [SW-1:0] s, bit typed, upmix_frame_t want);
    upmix_frame_t predicted;
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.sample_in <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = predict_upmix(s);
    expected_frames.push_back(typed ? want : predicted);
  endtask

  // Sender idle time after an item: usually none, sometimes a little, rarely a lot.
  task automatic sender_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = (r < 55) ? 0 : ((r < 90) ? $urandom_range(1, 4) : $urandom_range(10, 60));
    if (n > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  function automatic logic signed [15:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return G_MIN;
      1: return G_MAX;
      2: return G_RST;
      3: return 16'sd0;
      default: return 16'($urandom);
    endcase
  endfunction

  // Full-scale noise half of the time, with extremes and quiet passages mixed in so the
  // filters see both saturation and small-signal rounding.
  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return S_MAX;
      1: return S_MIN;
      2: return SW'(int'($urandom_range(0, 511)) - 256);
      3: return S_MAX - SW'($urandom_range(0, 15));
      4: return S_MIN + SW'($urandom_range(0, 15));
      default: return SW'($urandom);
    endcase
  endfunction

  initial begin
    int sent;
    int phase_len;
    bit paused;
    logic en;
    logic md;
    logic signed [15:0] g1;
    logic signed [15:0] g2;

    // Q2.22 coefficients, rounded to nearest with ties away from zero.
    for (int k = 0; k < 3; k++) begin
      for (int t = 0; t < 5; t++) begin
        longint mag;
        mag = longint'((coef_e4[k][t] < 0) ? -coef_e4[k][t] : coef_e4[k][t]) <<< FRAC;
        biquad_coef[k][t] = (mag + 5000) / 10000;
        if (coef_e4[k][t] < 0) biquad_coef[k][t] = -biquad_coef[k][t];
      end
    end
    for (int i = 0; i < 12; i++) begin
      x_hist[i] = 0;
      y_hist[i] = 0;
    end
    cur_enable      = 1'b1;
    cur_mode        = MODE_LEFT_DRY;
    cur_gain_first  = G_RST;
    cur_gain_second = G_RST;

    rst_n           = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_ch.valid     = 1'b0;
    in_ch.sample_in = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: each row brings its own register setting.
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (directed_rows[i].en !== cur_enable || directed_rows[i].md !== cur_mode ||
          directed_rows[i].g1 !== cur_gain_first || directed_rows[i].g2 !== cur_gain_second)
      begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        apply_setting(directed_rows[i].en, directed_rows[i].md,
                      directed_rows[i].g1, directed_rows[i].g2);
      end
      offer_sample(directed_rows[i].sample, directed_rows[i].typed, directed_rows[i].want);
      sender_gap();
    end

    // Random part: phases of random length, each under a fresh register setting. The
    // bypass is kept rare since it leaves the filters idle.
    sent = 0;
    paused = 0;
    while (sent < RANDOM_ITEMS) begin
      en = ($urandom_range(0, 7) != 0);
      md = $urandom_range(0, 1);
      g1 = pick_gain();
      g2 = pick_gain();
      @(negedge clk);
      in_ch.valid <= 1'b0;
      apply_setting(en, md, g1, g2);
      phase_len = $urandom_range(40, 200);
      for (int j = 0; j < phase_len && sent < RANDOM_ITEMS; j++) begin
        offer_sample(pick_sample(), 1'b0, ZERO_FRAME);
        sent++;
        if (!paused && sent >= 900) begin
          // Let the pipeline run completely dry once in the middle of a phase.
          paused = 1;
          @(negedge clk);
          in_ch.valid <= 1'b0;
          wait_drained();
        end else begin
          sender_gap();
        end
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
